### hdl/utf8_to_utf16_decoder_macros.svh
// Assertion macros shared by the UTF-8 to UTF-16 decoder.
`ifndef UTF8_TO_UTF16_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define U8U16_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8u16 check failed: same-cycle implication");

// Antecedent holds -> consequent holds in the next cycle.
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8u16 check failed: next-cycle implication");

`endif

### hdl/u8u16_pkg.sv
// Shared types and constants of the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_INPUT   = 2'd1;
    localparam logic [1:0] ST_BAD_PACKING = 2'd2;
    localparam logic [1:0] ST_TRUNCATED   = 2'd3;

    // Open sequence length codes (total bytes minus one)
    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_TWO   = 2'd1;
    localparam logic [1:0] LEN_THREE = 2'd2;
    localparam logic [1:0] LEN_FOUR  = 2'd3;

    // Depth of the result queue (power of two, at least 2)
    localparam int FIFO_DEPTH = 4;

    localparam int VALUE_W = 21;

    typedef struct packed {
        logic [1:0]         need;
        logic [1:0]         len;
        logic [VALUE_W-1:0] value;
        logic               discard;
    } t_state;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  status;
        logic        run_last;
        logic        stream_end;
    } t_result;

endpackage

### hdl/u8u16_if.sv
// Handshake channels of the decoder: input bytes and output code units.
interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface u8u16_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic [1:0]  status;
    logic        run_last;
    logic        stream_end;

    modport source (output valid, output code_unit, output status, output run_last,
                    output stream_end, input ready);
    modport sink   (input valid, input code_unit, input status, input run_last,
                    input stream_end, output ready);
endinterface

### hdl/u8u16_step.sv
// Decode step: next sequence state and up to two results for one byte.
module u8u16_step
    import u8u16_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte_value,
    input  logic       i_last_byte,
    output t_state     o_state,
    output logic [1:0] o_count,
    output t_result    o_res0,
    output t_result    o_res1
);

    logic [VALUE_W-1:0] w_packed;
    logic [1:0]         w_need_dec;
    logic [19:0]        w_offset;
    logic               w_err;
    logic [1:0]         w_err_status;

    assign w_packed   = {i_state.value[VALUE_W-7:0], i_byte_value[5:0]};
    assign w_need_dec = i_state.need - 2'd1;
    assign w_offset   = 20'(w_packed - VALUE_W'(32'h10000));

    always_comb begin
        o_state      = i_state;
        o_count      = 2'd0;
        o_res0       = '0;
        o_res1       = '0;
        w_err        = 1'b0;
        w_err_status = ST_OK;

        if (i_state.discard) begin
            // drop until the stream's last byte
            if (i_last_byte) begin
                o_state.discard = 1'b0;
            end
        end else if (i_state.need == 2'd0) begin
            if (i_byte_value[7] == 1'b0) begin
                o_res0  = '{code_unit: {8'h00, i_byte_value}, status: ST_OK,
                            run_last: 1'b1, stream_end: i_last_byte};
                o_count = 2'd1;
            end else if (i_byte_value[7:5] == 3'b110) begin
                o_state.len   = LEN_TWO;
                o_state.need  = 2'd1;
                o_state.value = VALUE_W'(i_byte_value[4:0]);
            end else if (i_byte_value[7:4] == 4'b1110) begin
                o_state.len   = LEN_THREE;
                o_state.need  = 2'd2;
                o_state.value = VALUE_W'(i_byte_value[3:0]);
            end else if (i_byte_value[7:3] == 5'b11110) begin
                o_state.len   = LEN_FOUR;
                o_state.need  = 2'd3;
                o_state.value = VALUE_W'(i_byte_value[2:0]);
            end else begin
                w_err        = 1'b1;
                w_err_status = ST_BAD_INPUT;
            end
            if (!w_err && i_byte_value[7] && i_last_byte) begin
                w_err        = 1'b1;
                w_err_status = ST_TRUNCATED;
            end
        end else if (i_byte_value[7:6] != 2'b10) begin
            w_err        = 1'b1;
            w_err_status = ST_BAD_INPUT;
        end else if (w_need_dec != 2'd0) begin
            o_state.value = w_packed;
            o_state.need  = w_need_dec;
            if (i_last_byte) begin
                w_err        = 1'b1;
                w_err_status = ST_TRUNCATED;
            end
        end else begin
            // sequence complete
            o_state.need  = 2'd0;
            o_state.len   = LEN_NONE;
            o_state.value = '0;
            case (i_state.len)
                LEN_TWO: begin
                    if (w_packed[10:0] < 11'h080) begin
                        w_err        = 1'b1;
                        w_err_status = ST_BAD_PACKING;
                    end else begin
                        o_res0  = '{code_unit: {5'd0, w_packed[10:0]}, status: ST_OK,
                                    run_last: 1'b1, stream_end: i_last_byte};
                        o_count = 2'd1;
                    end
                end
                LEN_THREE: begin
                    if (w_packed[15:0] < 16'h0800) begin
                        w_err        = 1'b1;
                        w_err_status = ST_BAD_PACKING;
                    end else if (w_packed[15:11] == 5'b11011) begin
                        // encoded surrogate
                        w_err        = 1'b1;
                        w_err_status = ST_BAD_INPUT;
                    end else begin
                        o_res0  = '{code_unit: w_packed[15:0], status: ST_OK,
                                    run_last: 1'b1, stream_end: i_last_byte};
                        o_count = 2'd1;
                    end
                end
                default: begin
                    if (w_packed < VALUE_W'(32'h10000)) begin
                        w_err        = 1'b1;
                        w_err_status = ST_BAD_PACKING;
                    end else if (w_packed > VALUE_W'(32'h10FFFF)) begin
                        w_err        = 1'b1;
                        w_err_status = ST_BAD_INPUT;
                    end else begin
                        // surrogate pair, high half first
                        o_res0  = '{code_unit: {6'b110110, w_offset[19:10]}, status: ST_OK,
                                    run_last: 1'b0, stream_end: 1'b0};
                        o_res1  = '{code_unit: {6'b110111, w_offset[9:0]}, status: ST_OK,
                                    run_last: 1'b1, stream_end: i_last_byte};
                        o_count = 2'd2;
                    end
                end
            endcase
        end

        if (w_err) begin
            o_state.need    = 2'd0;
            o_state.len     = LEN_NONE;
            o_state.value   = '0;
            o_state.discard = !i_last_byte;
            o_res0  = '{code_unit: 16'h0000, status: w_err_status,
                        run_last: 1'b1, stream_end: i_last_byte};
            o_res1  = '0;
            o_count = 2'd1;
        end
    end

endmodule

### hdl/utf8_to_utf16_decoder.sv
// Top level of the streaming UTF-8 to UTF-16 decoder.
//
// Takes one UTF-8 byte per word on i_byte, with last_byte marking the end of
// a stream, and delivers UTF-16 code units on o_unit. A byte enters an input
// register, one pass of decode logic updates the sequence state and writes
// zero, one or two result words into a small result queue (P_FIFO_DEPTH
// entries) that drives o_unit. Throughput is one byte per cycle; a byte's
// first result goes through the input register and then the result queue on its way to o_unit. The
// decode pass moves a byte forward only when the queue has room for two
// words, which sets the throughput under backpressure. A code point above
// 0xFFFF comes out as a surrogate pair on two consecutive words, high half
// first. Errors come out as one word with code_unit 0 and a nonzero status
// (1 bad input, 2 overlong, 3 truncated); after an error that is not on the
// last byte, bytes are dropped through the next last-byte marker. Lead and
// continuation bytes that do not finish a sequence produce no word unless they raise an error.
`include "utf8_to_utf16_decoder_macros.svh"

module utf8_to_utf16_decoder
    import u8u16_pkg::*;
#(
    parameter int P_FIFO_DEPTH = FIFO_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    u8u16_byte_if.sink          i_byte,
    u8u16_unit_if.source        o_unit
);

    localparam int AW = $clog2(P_FIFO_DEPTH);
    localparam int CW = $clog2(P_FIFO_DEPTH + 1);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // sequence state
    t_state     r_state;
    t_state     n_state;

    // result queue
    t_result    r_fifo [P_FIFO_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic [AW-1:0] w_wr_ptr_1;
    logic          w_adv;
    logic          w_pop;
    logic [1:0]    w_cnt;
    logic [1:0]    w_push;
    t_result       w_res0;
    t_result       w_res1;
    t_result       w_head;
    logic          w_pair_good;
    logic          w_err_word;

    u8u16_step u_step (
        .i_state      (r_state),
        .i_byte_value (r_in_byte),
        .i_last_byte  (r_in_last),
        .o_state      (n_state),
        .o_count      (w_cnt),
        .o_res0       (w_res0),
        .o_res1       (w_res1)
    );

    // advance the held byte only with room for a surrogate pair
    assign w_adv      = r_in_valid && (r_count <= CW'(P_FIFO_DEPTH - 2));
    assign w_push     = w_adv ? w_cnt : 2'd0;
    assign w_pop      = o_unit.valid && o_unit.ready;
    assign w_wr_ptr_1 = r_wr_ptr + AW'(1);

    assign i_byte.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.byte_value;
            r_in_last <= i_byte.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // write up to two words per decoded byte
    always_ff @(posedge i_clk) begin
        if (w_adv && w_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= w_res0;
        end
        if (w_adv && w_cnt == 2'd2) begin
            r_fifo[w_wr_ptr_1] <= w_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + AW'(w_push);
            r_rd_ptr <= r_rd_ptr + AW'(w_pop);
            r_count  <= r_count + CW'(w_push) - CW'(w_pop);
        end
    end

    assign w_head            = r_fifo[r_rd_ptr];
    assign o_unit.valid      = (r_count != '0);
    assign o_unit.code_unit  = w_head.code_unit;
    assign o_unit.status     = w_head.status;
    assign o_unit.run_last   = w_head.run_last;
    assign o_unit.stream_end = w_head.stream_end;

    assign w_pair_good = !w_res0.run_last && w_res0.status == ST_OK && w_res1.status == ST_OK;
    assign w_err_word  = w_adv && w_cnt == 2'd1 && w_res0.status != ST_OK;

    // queue never overfills
    `U8U16_ASSERT_SAME(a_queue_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(P_FIFO_DEPTH))
    // a pair is two good words, the first never closing the byte
    `U8U16_ASSERT_SAME(a_pair_shape, i_clk, i_rst_n, w_adv && w_cnt == 2'd2, w_pair_good)
    // an error before the stream's end starts discarding
    `U8U16_ASSERT_NEXT(a_error_discard, i_clk, i_rst_n, w_err_word && !r_in_last, r_state.discard)

endmodule

### verif/tb_utf8_to_utf16_decoder.sv
// Self-checking testbench of the UTF-8 to UTF-16 decoder: directed and random byte streams.
`timescale 1ns / 100ps

module tb_utf8_to_utf16_decoder;
    import u8u16_pkg::*;

    // Clock period and run limits
    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_BYTES = 800;
    // Cycles of held-off ready while the sender keeps pushing words
    localparam int HOLD_CYCLES  = 200;
    // Cycles to keep watching after the last expected word
    localparam int DRAIN_CYCLES = 16;
    // Cycles with no word moving on either side before the run is given up
    localparam int QUIET_LIMIT  = 4000;
    // Idle chance per cycle, in percent
    localparam int IDLE_PCT     = 35;

    // Predicts the code unit words of the decoder and checks the ones that come out.
    class code_unit_predictor;
        t_result     awaited_units[$];
        int          mismatches;
        logic [1:0]  need;
        logic [1:0]  seq_len;
        logic [20:0] acc;
        logic        dropping;

        function new();
            mismatches = 0;
            need       = 2'd0;
            seq_len    = LEN_NONE;
            acc        = '0;
            dropping   = 1'b0;
        endfunction

        function void push_unit(input logic [15:0] unit, input logic [1:0] status,
                                input logic run_last, input logic stream_end);
            t_result word;
            word.code_unit  = unit;
            word.status     = status;
            word.run_last   = run_last;
            word.stream_end = stream_end;
            awaited_units.push_back(word);
        endfunction

        // Report one error word, close the sequence, and drop bytes up to the
        // next last-byte marker unless this byte is that marker.
        function void flag_error(input logic [1:0] status, input logic lst);
            need     = 2'd0;
            seq_len  = LEN_NONE;
            acc      = '0;
            dropping = !lst;
            push_unit(16'h0000, status, 1'b1, lst);
        endfunction

        // Advance the decode state by one accepted byte.
        function void take_byte(input logic [7:0] b, input logic lst);
            logic [20:0] cp;
            logic [1:0]  len_code;
            logic [19:0] offset;
            if (dropping) begin
                if (lst)
                    dropping = 1'b0;
                return;
            end
            if (need == 2'd0) begin
                if (!b[7]) begin
                    push_unit({8'h00, b}, ST_OK, 1'b1, lst);
                    return;
                end
                if (b[7:5] == 3'b110) begin
                    seq_len = LEN_TWO;
                    need    = 2'd1;
                    acc     = {16'd0, b[4:0]};
                end else if (b[7:4] == 4'b1110) begin
                    seq_len = LEN_THREE;
                    need    = 2'd2;
                    acc     = {17'd0, b[3:0]};
                end else if (b[7:3] == 5'b11110) begin
                    seq_len = LEN_FOUR;
                    need    = 2'd3;
                    acc     = {18'd0, b[2:0]};
                end else begin
                    flag_error(ST_BAD_INPUT, lst);
                    return;
                end
                if (lst)
                    flag_error(ST_TRUNCATED, lst);
                return;
            end
            // Check the continuation form before anything about the stream end
            if (b[7:6] != 2'b10) begin
                flag_error(ST_BAD_INPUT, lst);
                return;
            end
            acc  = {acc[14:0], b[5:0]};
            need = need - 2'd1;
            if (need != 2'd0) begin
                if (lst)
                    flag_error(ST_TRUNCATED, lst);
                return;
            end
            cp       = acc;
            len_code = seq_len;
            seq_len  = LEN_NONE;
            acc      = '0;
            case (len_code)
                LEN_TWO: begin
                    if (cp[10:0] < 11'h080)
                        flag_error(ST_BAD_PACKING, lst);
                    else
                        push_unit({5'd0, cp[10:0]}, ST_OK, 1'b1, lst);
                end
                LEN_THREE: begin
                    if (cp[15:0] < 16'h0800)
                        flag_error(ST_BAD_PACKING, lst);
                    else if (cp[15:0] >= 16'hD800 && cp[15:0] <= 16'hDFFF)
                        flag_error(ST_BAD_INPUT, lst);
                    else
                        push_unit(cp[15:0], ST_OK, 1'b1, lst);
                end
                default: begin
                    if (cp < 21'h010000) begin
                        flag_error(ST_BAD_PACKING, lst);
                    end else if (cp > 21'h10FFFF) begin
                        flag_error(ST_BAD_INPUT, lst);
                    end else begin
                        offset = 20'(cp - 21'h010000);
                        push_unit(16'hD800 + {6'd0, offset[19:10]}, ST_OK, 1'b0, 1'b0);
                        push_unit(16'hDC00 + {6'd0, offset[9:0]}, ST_OK, 1'b1, lst);
                    end
                end
            endcase
        endfunction

        // Compare one output word against the oldest prediction, field by field.
        function void check_word(input t_result got);
            t_result want;
            if (awaited_units.size() == 0) begin
                $error("unexpected word: code_unit %h status %0d run_last %0b stream_end %0b",
                       got.code_unit, got.status, got.run_last, got.stream_end);
                mismatches++;
                return;
            end
            want = awaited_units.pop_front();
            if (got.code_unit !== want.code_unit) begin
                $error("code_unit: expected %h, got %h", want.code_unit, got.code_unit);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
                mismatches++;
            end
            if (got.stream_end !== want.stream_end) begin
                $error("stream_end: expected %0b, got %0b", want.stream_end, got.stream_end);
                mismatches++;
            end
        endfunction

        function int pending();
            return awaited_units.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    u8u16_byte_if byte_ch();
    u8u16_unit_if unit_ch();

    code_unit_predictor book = new();

    // The stimulus sets both flags; the receiver clears hold_request after its hold-off
    logic no_idle;
    logic hold_request;
    int   quiet_cycles;

    utf8_to_utf16_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_unit  (unit_ch)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic logic idle_roll();
        return !no_idle && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Offer one byte and hold it until the decoder takes it. Valid stays high
    // between back-to-back words; it only drops during an idle gap.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        while (idle_roll()) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.byte_value <= b;
        byte_ch.last_byte  <= lst;
        @(posedge i_clk);
        while (!byte_ch.ready)
            @(posedge i_clk);
        book.take_byte(b, lst);
    endtask

    // Build one character of random content and send it. Most characters are
    // well formed; the rest are noise bytes, overlong or out-of-range values,
    // corrupted continuations and streams cut off mid-sequence.
    task automatic send_random_char(inout int sent);
        int          kind;
        int          nbytes;
        int          cut;
        int          i;
        logic [20:0] cp;
        logic [7:0]  seq [4];
        logic        end_mark;
        kind = $urandom_range(99);
        if (kind < 8) begin
            send_byte(8'($urandom_range(255)), ($urandom_range(7) == 0));
            sent++;
            return;
        end
        nbytes = $urandom_range(1, 4);
        case (nbytes)
            1: cp = 21'($urandom_range(8'h7F));
            2: cp = (kind < 14) ? 21'($urandom_range(8'h7F))
                                : 21'($urandom_range(11'h080, 11'h7FF));
            3: cp = (kind < 14) ? 21'($urandom_range(11'h7FF))
                                : 21'($urandom_range(16'h0800, 16'hFFFF));
            default: begin
                if (kind < 14)
                    cp = 21'($urandom_range(16'hFFFF));
                else if (kind < 18)
                    cp = 21'($urandom_range(21'h110000, 21'h1FFFFF));
                else
                    cp = 21'($urandom_range(21'h010000, 21'h10FFFF));
            end
        endcase
        case (nbytes)
            1: seq[0] = {1'b0, cp[6:0]};
            2: begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        // Corrupt one continuation byte
        if (kind >= 18 && kind < 24 && nbytes > 1)
            seq[$urandom_range(1, nbytes - 1)] = 8'($urandom_range(255));
        cut      = nbytes;
        end_mark = ($urandom_range(9) == 0);
        // End the stream in the middle of the sequence
        if (kind >= 24 && kind < 30 && nbytes > 1) begin
            cut      = $urandom_range(1, nbytes - 1);
            end_mark = 1'b1;
        end
        for (i = 0; i < cut; i++) begin
            send_byte(seq[i], end_mark && (i == cut - 1));
            sent++;
        end
    endtask

    // Receiver: random ready, a steady stretch while no_idle is set, and one
    // long hold-off on request so the result queue fills and stalls the input.
    initial begin
        unit_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                unit_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            unit_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Check every word the decoder hands over
    always @(posedge i_clk) begin
        if (i_rst_n && unit_ch.valid && unit_ch.ready)
            book.check_word({unit_ch.code_unit, unit_ch.status, unit_ch.run_last,
                             unit_ch.stream_end});
    end

    // Give up when no word moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_ch.valid && byte_ch.ready) || (unit_ch.valid && unit_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int  sent;
        logic hold_done;
        sent      = 0;
        hold_done = 1'b0;
        no_idle      = 1'b0;
        hold_request = 1'b0;
        quiet_cycles <= 0;
        i_rst_n            <= 1'b0;
        byte_ch.valid      <= 1'b0;
        byte_ch.byte_value <= 8'h00;
        byte_ch.last_byte  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ASCII extremes
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        // Smallest two-byte value
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        // Largest three-byte value
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // Largest code point as a surrogate pair, ending the stream
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
        // Overlong two-byte form on the last byte
        send_byte(8'hC0, 1'b0);
        send_byte(8'hAF, 1'b1);
        // Encoded surrogate
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b1);
        // Four-byte value above the Unicode range
        send_byte(8'hF4, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);
        // Bad lead byte mid-stream, then drop through the end marker
        send_byte(8'hFF, 1'b0);
        send_byte(8'h41, 1'b1);
        // Bad continuation byte that is also the last byte
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b1);
        // Stream cut off inside a four-byte sequence
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b1);

        while (sent < RANDOM_BYTES) begin
            // Run a stretch with no idling on either side
            no_idle = (sent >= 300 && sent < 450);
            if (sent >= 550 && !hold_done) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            send_random_char(sent);
        end
        no_idle = 1'b0;
        byte_ch.valid <= 1'b0;

        // Wait for the outstanding words, then watch for strays
        while (book.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (book.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
